>>> rtl/core/uaf_pkg.sv
package uaf_pkg;

   // Field widths.
   localparam int ByteW  = 8;
   localparam int CharW  = 7;
   localparam int CapW   = 9;
   localparam int CountW = 8;
   localparam int ModeW  = 2;

   // Capacity limits and reset value.
   localparam logic [CapW-1:0] CapReset = 9'd64;
   localparam logic [CapW-1:0] CapMax   = 9'd256;
   localparam logic [CapW-1:0] CapMin   = 9'd1;

   // Decoder modes.
   localparam logic [ModeW-1:0] ModePlain   = 2'd0;
   localparam logic [ModeW-1:0] ModeAfterC3 = 2'd1;
   localparam logic [ModeW-1:0] ModeSkip    = 2'd2;

   // Byte classes.
   localparam logic [ByteW-1:0] ByteLeadC3  = 8'hC3;
   localparam logic [ByteW-1:0] ByteAscii   = 8'h80;
   localparam logic [ByteW-1:0] ByteLeadMin = 8'hC0;
   localparam logic [CharW-1:0] CharUnknown = 7'h3F;
   localparam logic [CharW-1:0] CharTerm    = 7'h00;

   // One result beat.
   typedef struct packed {
      logic             valid;
      logic [CharW-1:0] out_char;
      logic             is_end;
   } result_type;

   // Folds the byte after a 0xC3 lead to a plain Latin letter.
   function automatic logic [CharW-1:0] fold_latin1(input logic [ByteW-1:0] d);
      logic [CharW-1:0] c;
      c = CharUnknown;
      if (d >= 8'h80 && d <= 8'h85) c = 7'h41;       // A
      else if (d >= 8'hA0 && d <= 8'hA5) c = 7'h61;  // a
      else if (d == 8'h87) c = 7'h43;                // C
      else if (d == 8'hA7) c = 7'h63;                // c
      else if (d >= 8'h88 && d <= 8'h8B) c = 7'h45;  // E
      else if (d >= 8'hA8 && d <= 8'hAB) c = 7'h65;  // e
      else if (d >= 8'h8C && d <= 8'h8F) c = 7'h49;  // I
      else if (d >= 8'hAC && d <= 8'hAF) c = 7'h69;  // i
      else if (d == 8'h91) c = 7'h4E;                // N
      else if (d == 8'hB1) c = 7'h6E;                // n
      else if (d >= 8'h92 && d <= 8'h96) c = 7'h4F;  // O
      else if (d >= 8'hB2 && d <= 8'hB6) c = 7'h6F;  // o
      else if (d >= 8'h99 && d <= 8'h9C) c = 7'h55;  // U
      else if (d >= 8'hB9 && d <= 8'hBC) c = 7'h75;  // u
      else if (d == 8'h9F) c = 7'h73;                // sharp s folds to s
      return c;
   endfunction

endpackage

>>> rtl/core/uaf_in_stage.sv
module uaf_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [uaf_pkg::ByteW-1:0]  req_in_byte,
   input  logic                       advance,
   output logic                       byte_valid,
   output logic [uaf_pkg::ByteW-1:0]  byte_data
);

   logic                      valid_ff;
   logic                      valid_in;
   logic [uaf_pkg::ByteW-1:0] data_ff;
   logic                      take;

   // The stage takes a new beat whenever it is empty or is being drained.
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_in_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

>>> rtl/core/uaf_decode.sv
module uaf_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [uaf_pkg::CapW-1:0]   csr_wr_data,
   input  logic                       step,
   input  logic [uaf_pkg::ByteW-1:0]  byte_data,
   output uaf_pkg::result_type        result
);

   logic [uaf_pkg::CapW-1:0]   cap_ff;
   logic [uaf_pkg::ModeW-1:0]  mode_ff;
   logic [uaf_pkg::ModeW-1:0]  mode_in;
   logic [uaf_pkg::CountW-1:0] count_ff;
   logic [uaf_pkg::CountW-1:0] count_in;
   logic [uaf_pkg::CapW-1:0]   cap_eff;
   logic [uaf_pkg::CapW-1:0]   count_next;
   logic                       full;
   logic                       is_cont;

   // Capacity register; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= uaf_pkg::CapReset;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Clamp capacity to the range one through 256.
   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff == '0) begin
         cap_eff = uaf_pkg::CapMin;
      end else if (cap_ff > uaf_pkg::CapMax) begin
         cap_eff = uaf_pkg::CapMax;
      end
   end

   assign count_next = {1'b0, count_ff} + 9'd1;
   assign full       = count_next >= cap_eff;
   assign is_cont    = byte_data >= uaf_pkg::ByteAscii && byte_data < uaf_pkg::ByteLeadMin;

   // Mode and count update together with the character to emit.
   always_comb begin
      mode_in         = mode_ff;
      count_in        = count_ff;
      result.valid    = 1'b0;
      result.out_char = uaf_pkg::CharTerm;
      result.is_end   = 1'b0;
      if (step) begin
         priority if (byte_data == '0) begin
            result.valid  = 1'b1;
            result.is_end = 1'b1;
            mode_in       = uaf_pkg::ModePlain;
            count_in      = '0;
         end else if (full) begin
            // Buffer full: drop everything up to the terminator.
         end else if (mode_ff == uaf_pkg::ModeAfterC3) begin
            mode_in         = uaf_pkg::ModePlain;
            result.valid    = 1'b1;
            result.out_char = uaf_pkg::fold_latin1(byte_data);
            count_in        = count_next[uaf_pkg::CountW-1:0];
         end else if (mode_ff == uaf_pkg::ModeSkip && is_cont) begin
            // Continuation of an unsupported sequence is dropped.
         end else if (byte_data < uaf_pkg::ByteAscii) begin
            mode_in         = uaf_pkg::ModePlain;
            result.valid    = 1'b1;
            result.out_char = byte_data[uaf_pkg::CharW-1:0];
            count_in        = count_next[uaf_pkg::CountW-1:0];
         end else if (byte_data == uaf_pkg::ByteLeadC3) begin
            mode_in = uaf_pkg::ModeAfterC3;
         end else begin
            mode_in = uaf_pkg::ModeSkip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= uaf_pkg::ModePlain;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/uaf_out_stage.sv
module uaf_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  uaf_pkg::result_type        result,
   output logic                       ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [uaf_pkg::CharW-1:0]  rsp_out_char,
   output logic                       rsp_is_end
);

   logic                      valid_ff;
   logic                      valid_in;
   logic [uaf_pkg::CharW-1:0] char_ff;
   logic                      end_ff;

   // The register can load when empty or when its beat leaves this cycle.
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (ready) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && result.valid) begin
         char_ff <= result.out_char;
         end_ff  <= result.is_end;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_is_end   = end_ff;

endmodule

>>> rtl/core/utf8_accent_fold_to_ascii.sv
// Folds a zero-terminated UTF-8 byte stream to ASCII, one byte per beat. Each
// byte is registered on entry, decoded against the mode and count registers
// when the result register can take it, and its character (if any) lands in
// the result register; a new byte is taken every cycle while the result side
// keeps up. A byte that yields no character still passes through decode. The
// capacity register (reset 64) is written through csr_wr_en and csr_wr_data;
// the user must do so only while no byte is in flight, which the block does
// not enforce. A new value applies from the next byte, also mid-string.
module utf8_accent_fold_to_ascii (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [uaf_pkg::ByteW-1:0]  req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [uaf_pkg::CharW-1:0]  rsp_out_char,
   output logic                       rsp_is_end,
   input  logic                       csr_wr_en,
   input  logic [uaf_pkg::CapW-1:0]   csr_wr_data
);

   logic                      byte_valid;
   logic [uaf_pkg::ByteW-1:0] byte_data;
   logic                      out_ready;
   logic                      step;
   uaf_pkg::result_type       result;

   // A held byte is decoded when the result register can take its outcome.
   assign step = byte_valid && out_ready;

   uaf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (step),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   uaf_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .byte_data   (byte_data),
      .result      (result)
   );

   uaf_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .ready        (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_is_end   (rsp_is_end)
   );

endmodule

>>> rtl/core/uaf_checker.sv
module uaf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [uaf_pkg::CharW-1:0]  rsp_out_char,
   input logic                       rsp_is_end
);

   // No result beat right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_is_end))
      else $error("stalled result changed");

   // The terminator carries a zero character.
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_out_char == uaf_pkg::CharTerm)
      else $error("terminator with nonzero character");

   // Ordinary characters are never zero.
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_out_char != uaf_pkg::CharTerm)
      else $error("zero character without end flag");

   // The input side never stalls while the pipeline is empty.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid) |-> !req_stall)
      else $error("input stalled with empty pipeline");

endmodule

bind utf8_accent_fold_to_ascii uaf_checker u_uaf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_is_end   (rsp_is_end)
);
